// File: rtl/wsdf_pkg.sv
// Package for the WebSocket frame deframer: result kinds, header length codes
// and the result record passed from the parser to the output stage. No dependencies.
`default_nettype none

package wsdf_pkg;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_UNMASKED = 2'd2;
    localparam logic [1:0] KIND_CLOSED   = 2'd3;

    localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16      = 7'd126;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [3:0] OPCODE_MASK = 4'hF;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] payload;
        logic [3:0] opcode;
        logic       last;
    } wsdf_result_t;

endpackage

`default_nettype wire

// File: rtl/wsdf_parser.sv
// Frame header parser and payload unmasker for the WebSocket frame deframer.
// Depends on wsdf_pkg; produces at most one result record per accepted byte.
`default_nettype none

module wsdf_parser (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  take,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  stream_closed,
    output wsdf_pkg::wsdf_result_t     result
);
    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0       = 3'd0,
        PH_HDR1       = 3'd1,
        PH_EXT        = 3'd2,
        PH_EXT_NOMASK = 3'd3,
        PH_KEY        = 3'd4,
        PH_PAYLOAD    = 3'd5
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         fin_reg, fin_next;
    logic [3:0]   left_reg, left_next;
    logic [63:0]  rem_reg, rem_next;
    logic [31:0]  key_reg, key_next;
    logic [1:0]   pos_reg, pos_next;
    logic [3:0]   opcode_reg, opcode_next;
    logic         in_msg_reg, in_msg_next;

    logic [3:0]   left_dec;
    logic [63:0]  rem_dec;
    logic [7:0]   key_byte;
    logic         len_done;
    logic         masked;

    assign left_dec = left_reg - 4'd1;
    assign rem_dec  = rem_reg - 64'd1;

    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        left_next   = left_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        opcode_next = opcode_reg;
        in_msg_next = in_msg_reg;
        result      = '0;
        len_done    = 1'b0;
        masked      = 1'b0;

        if (stream_closed) begin
            phase_next   = PH_HDR0;
            fin_next     = 1'b0;
            left_next    = '0;
            rem_next     = '0;
            key_next     = '0;
            pos_next     = '0;
            opcode_next  = '0;
            in_msg_next  = 1'b0;
            result.valid = 1'b1;
            result.kind  = KIND_CLOSED;
        end else begin
            case (phase_reg)
                PH_HDR1: begin
                    masked = data_byte[7];
                    if (data_byte[6:0] <= LEN_DIRECT_MAX) begin
                        rem_next = {57'd0, data_byte[6:0]};
                        len_done = 1'b1;
                    end else begin
                        rem_next   = '0;
                        left_next  = (data_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        phase_next = masked ? PH_EXT : PH_EXT_NOMASK;
                    end
                end
                PH_EXT, PH_EXT_NOMASK: begin
                    masked    = (phase_reg == PH_EXT);
                    rem_next  = {rem_reg[55:0], data_byte};
                    left_next = left_dec;
                    len_done  = (left_dec == 4'd0);
                end
                PH_KEY: begin
                    key_next  = {key_reg[23:0], data_byte};
                    left_next = left_dec;
                    if (left_dec == 4'd0) begin
                        pos_next = '0;
                        if (rem_reg != 64'd0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            phase_next = PH_HDR0;
                            if (fin_reg) begin
                                in_msg_next   = 1'b0;
                                result.valid  = 1'b1;
                                result.kind   = KIND_END;
                                result.opcode = opcode_reg;
                                result.last   = 1'b1;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    pos_next       = pos_reg + 2'd1;
                    rem_next       = rem_dec;
                    result.valid   = 1'b1;
                    result.kind    = KIND_BYTE;
                    result.payload = data_byte ^ key_byte;
                    result.opcode  = opcode_reg;
                    if (rem_dec == 64'd0) begin
                        phase_next = PH_HDR0;
                        if (fin_reg) begin
                            result.last = 1'b1;
                            in_msg_next = 1'b0;
                        end
                    end
                end
                default: begin
                    fin_next = data_byte[7];
                    if (!in_msg_reg) begin
                        opcode_next = data_byte[3:0] & OPCODE_MASK;
                        in_msg_next = 1'b1;
                    end
                    phase_next = PH_HDR1;
                end
            endcase

            if (len_done) begin
                if (!masked) begin
                    phase_next   = PH_HDR0;
                    in_msg_next  = 1'b0;
                    result.valid = 1'b1;
                    result.kind  = KIND_UNMASKED;
                end else begin
                    phase_next = PH_KEY;
                    left_next  = KEY_BYTES;
                    key_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            left_reg   <= '0;
            rem_reg    <= '0;
            key_reg    <= '0;
            pos_reg    <= '0;
            opcode_reg <= '0;
            in_msg_reg <= 1'b0;
        end else if (take) begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            left_reg   <= left_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            opcode_reg <= opcode_next;
            in_msg_reg <= in_msg_next;
        end
    end

    // Length and key phases always have at least one byte still to come.
    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_EXT || phase_reg == PH_EXT_NOMASK || phase_reg == PH_KEY)
        |-> left_reg != 4'd0)
        else $error("length or key phase with no bytes left");

    // The payload phase is only entered with a nonzero byte count.
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> rem_reg != 64'd0)
        else $error("payload phase with zero remaining length");

    // A closed connection returns the parser to a fresh header wait.
    a_closed_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && stream_closed |=> phase_reg == PH_HDR0 && !in_msg_reg && rem_reg == 64'd0)
        else $error("state not cleared after connection closed");

    // Payload bytes come only from the payload phase.
    a_byte_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        take && result.valid && result.kind == KIND_BYTE |-> phase_reg == PH_PAYLOAD)
        else $error("payload byte produced outside payload phase");

endmodule

`default_nettype wire

// File: rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input handshake and the result register.
// Depends on wsdf_pkg and wsdf_parser.
//
//  channel   dir  tdata                                  tuser              tlast
//  s_        in   [7:0] data byte                        [0] stream closed  -
//  m_        out  [7:0] payload, [11:8] opcode, 15:12 0  [1:0] result kind  last in message
//
// One byte is taken per clock while m_ is not stalled; its result, if any, appears in m_ the next cycle.
// The header state and the 64-bit length count update in the accepting cycle.
// The single result register lets s_tready stay high while m_tready is high.
// Reset is synchronous on aresetn and clears all parser state and the output valid.
// A stalled result holds and blocks input only while m_tready is low.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] stream_closed
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [7:0] payload_byte, [11:8] msg_opcode, rest zero
    output      logic [1:0]  m_tuser,   // [1:0] kind
    output      logic        m_tlast    // last_in_message
);
    import wsdf_pkg::*;

    wsdf_result_t result;
    logic         take;

    logic         valid_reg, valid_next;
    logic [7:0]   payload_reg;
    logic [3:0]   opcode_reg;
    logic [1:0]   kind_reg;
    logic         last_reg;

    assign s_tready = !valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    wsdf_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .data_byte     (s_tdata),
        .stream_closed (s_tuser[0]),
        .result        (result)
    );

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = result.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && result.valid) begin
            payload_reg <= result.payload;
            opcode_reg  <= result.opcode;
            kind_reg    <= result.kind;
            last_reg    <= result.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, opcode_reg, payload_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: sim/tb_websocket_frame_deframer.sv
// Testbench for websocket_frame_deframer: it streams WebSocket frames, broken frames and
// connection closes into the block and checks each result transfer against its own parser.
// Depends on wsdf_pkg and the RTL of the deframer.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

    import wsdf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam logic [6:0]  LEN_EXT64_CODE = 7'd127;

    typedef enum logic [2:0] {
        HDR_FIRST, HDR_LEN, EXT_MASKED, EXT_UNMASKED, MASK_KEY, PAYLOAD
    } parse_phase_t;

    typedef enum int { ENC_DIRECT, ENC_EXT16, ENC_EXT64 } len_enc_t;

    typedef struct {
        logic [7:0] data;
        logic       closed;
    } wire_byte_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] payload;
        logic [3:0] opcode;
        logic       last;
    } deframed_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    wire_byte_t  wire_bytes[$];
    deframed_t   deframed_q[$];
    int          bytes_queued = 0;
    int          errors = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          offer_taken = 1'b0;

    parse_phase_t phase = HDR_FIRST;
    logic         frame_fin = 1'b0;
    logic [3:0]   ext_left = 4'd0;
    logic [63:0]  rem_len = 64'd0;
    logic [31:0]  key_reg = 32'd0;
    logic [1:0]   key_pos = 2'd0;
    logic [3:0]   msg_opcode = 4'd0;
    logic         in_msg = 1'b0;

    websocket_frame_deframer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic length_known(input logic masked, output logic emit, output deframed_t r);
        emit = 1'b0;
        r = '{KIND_UNMASKED, 8'd0, 4'd0, 1'b0};
        if (!masked) begin
            phase = HDR_FIRST;
            in_msg = 1'b0;
            emit = 1'b1;
        end else begin
            phase = MASK_KEY;
            ext_left = KEY_BYTES;
            key_reg = 32'd0;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic closed);
        deframed_t  r;
        logic       emit;
        logic [7:0] kb;
        r = '{KIND_BYTE, 8'd0, 4'd0, 1'b0};
        emit = 1'b0;
        if (closed) begin
            phase = HDR_FIRST;
            frame_fin = 1'b0;
            ext_left = 4'd0;
            rem_len = 64'd0;
            key_reg = 32'd0;
            key_pos = 2'd0;
            msg_opcode = 4'd0;
            in_msg = 1'b0;
            r.kind = KIND_CLOSED;
            emit = 1'b1;
        end else begin
            case (phase)
                HDR_LEN: begin
                    rem_len = 64'd0;
                    if (b[6:0] <= LEN_DIRECT_MAX) begin
                        rem_len = {57'd0, b[6:0]};
                        length_known(b[7], emit, r);
                    end else begin
                        ext_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        phase = b[7] ? EXT_MASKED : EXT_UNMASKED;
                    end
                end
                EXT_MASKED, EXT_UNMASKED: begin
                    rem_len = {rem_len[55:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0) begin
                        length_known(phase == EXT_MASKED, emit, r);
                    end
                end
                MASK_KEY: begin
                    key_reg = {key_reg[23:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0) begin
                        key_pos = 2'd0;
                        if (rem_len != 64'd0) begin
                            phase = PAYLOAD;
                        end else begin
                            phase = HDR_FIRST;
                            if (frame_fin) begin
                                in_msg = 1'b0;
                                r = '{KIND_END, 8'd0, msg_opcode, 1'b1};
                                emit = 1'b1;
                            end
                        end
                    end
                end
                PAYLOAD: begin
                    kb = key_reg[31 - 8 * key_pos -: 8];
                    key_pos = key_pos + 2'd1;
                    rem_len = rem_len - 64'd1;
                    r = '{KIND_BYTE, b ^ kb, msg_opcode, 1'b0};
                    if (rem_len == 64'd0) begin
                        phase = HDR_FIRST;
                        if (frame_fin) begin
                            r.last = 1'b1;
                            in_msg = 1'b0;
                        end
                    end
                    emit = 1'b1;
                end
                default: begin
                    frame_fin = b[7];
                    if (!in_msg) begin
                        msg_opcode = b[3:0] & OPCODE_MASK;
                        in_msg = 1'b1;
                    end
                    phase = HDR_LEN;
                end
            endcase
        end
        if (emit) begin
            deframed_q.push_back(r);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        wire_bytes.push_back('{b, 1'b0});
        bytes_queued++;
    endtask

    task automatic push_close();
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        wire_bytes.push_back('{junk, 1'b1});
        bytes_queued++;
    endtask

    task automatic push_frame(input logic fin, input logic [3:0] opc, input logic masked,
                              input len_enc_t enc, input logic [63:0] len, input int npay);
        logic [2:0] rsv;
        int         i;
        rsv = 3'($urandom_range(7));
        push_byte({fin, rsv, opc});
        case (enc)
            ENC_DIRECT: push_byte({masked, len[6:0]});
            ENC_EXT16: begin
                push_byte({masked, LEN_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, LEN_EXT64_CODE});
                for (i = 7; i >= 0; i--) begin
                    push_byte(len[8 * i +: 8]);
                end
            end
        endcase
        if (masked) begin
            for (i = 0; i < 4 + npay; i++) begin
                push_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic push_random_unit();
        int          sel;
        int          nfr;
        int          f;
        int          i;
        int          lsel;
        logic [3:0]  opc;
        logic [63:0] len;
        len_enc_t    enc;
        sel = $urandom_range(99);
        if (sel < 65) begin
            nfr = $urandom_range(1, 3);
            opc = 4'($urandom_range(15));
            for (f = 0; f < nfr; f++) begin
                lsel = $urandom_range(99);
                if (lsel < 72) begin
                    enc = ENC_DIRECT;
                    len = 64'($urandom_range(0, 12));
                end else if (lsel < 76) begin
                    enc = ENC_DIRECT;
                    len = 64'($urandom_range(120, 125));
                end else if (lsel < 90) begin
                    enc = ENC_EXT16;
                    len = 64'($urandom_range(0, 20));
                end else begin
                    enc = ENC_EXT64;
                    len = 64'($urandom_range(0, 20));
                end
                push_frame(f == nfr - 1, (f == 0) ? opc : 4'($urandom_range(15)), 1'b1,
                           enc, len, int'(len));
                if (f < nfr - 1 && $urandom_range(19) == 0) begin
                    push_close();
                    break;
                end
            end
        end else if (sel < 75) begin
            enc = len_enc_t'($urandom_range(2));
            len = {$urandom, $urandom};
            if (enc == ENC_DIRECT) begin
                len = 64'($urandom_range(0, 125));
            end
            push_frame(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b0, enc, len, 0);
            if ($urandom_range(1) == 1) begin
                nfr = $urandom_range(1, 5);
                for (i = 0; i < nfr; i++) begin
                    push_byte(8'($urandom_range(255)));
                end
                push_close();
            end
        end else if (sel < 83) begin
            push_close();
        end else if (sel < 93) begin
            if ($urandom_range(1) == 1) begin
                enc = ENC_EXT16;
                len = 64'($urandom_range(16'hFFFF, 16'h0100));
            end else begin
                enc = ENC_EXT64;
                len = {$urandom, $urandom} | 64'h100;
            end
            push_frame(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b1, enc, len,
                       int'($urandom_range(0, 10)));
            push_close();
        end else begin
            nfr = $urandom_range(1, 6);
            for (i = 0; i < nfr; i++) begin
                push_byte(8'($urandom_range(255)));
            end
            push_close();
        end
    endtask

    task automatic drain();
        while (wire_bytes.size() != 0 || deframed_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Sender: bursts of transfers with random gaps; an offered byte is held until taken.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        logic give;
        if (!(s_tvalid && !offer_taken)) begin
            give = 1'b0;
            if (aresetn) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (wire_bytes.size() != 0) begin
                    give = 1'b1;
                    if (burst_left == 0) begin
                        if ($urandom_range(3) == 0) begin
                            burst_left = $urandom_range(100, 200);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 30);
                            gap_left = $urandom_range(1, 8);
                        end
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_tvalid <= give;
            if (give) begin
                s_tdata <= wire_bytes[0].data;
                s_tuser <= wire_bytes[0].closed;
            end
        end
        offer_taken = 1'b0;
    end

    // Receiver: changing stall patterns, plus one long hold-off that backs up the input.
    int   stall_left = 0;
    bit   long_stall_done = 1'b0;
    int   mode_left = 0;
    int   rx_mode = 0;

    always @(negedge aclk) begin
        logic rdy;
        if (!long_stall_done && results_seen >= 120) begin
            stall_left = 400;
            long_stall_done = 1'b1;
        end
        if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(2);
                mode_left = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(1));
                default: rdy = ($urandom_range(9) != 0);
            endcase
        end
        m_tready <= rdy;
    end

    always @(posedge aclk) begin
        deframed_t want;
        logic      moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                results_seen++;
                if (deframed_q.size() == 0) begin
                    $error("unexpected result transfer: kind %0d, tdata %h", m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = deframed_q.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== want.payload) begin
                        $error("payload_byte: expected %h, got %h", want.payload, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[11:8] !== want.opcode) begin
                        $error("msg_opcode: expected %h, got %h", want.opcode, m_tdata[11:8]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_in_message: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tdata[15:12] !== 4'd0) begin
                        $error("tdata padding: expected 0, got %h", m_tdata[15:12]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                deframe_byte(s_tdata, s_tuser[0]);
                wire_bytes.delete(0);
                offer_taken = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        // Zero-length final frame, then unmasked frames with a short and a 16-bit length.
        push_frame(1'b1, 4'h1, 1'b1, ENC_DIRECT, 64'd0, 0);
        push_frame(1'b1, 4'h2, 1'b0, ENC_DIRECT, 64'd5, 0);
        push_frame(1'b1, 4'h2, 1'b0, ENC_EXT16, 64'h0100, 0);
        // Empty non-final frame, then a control frame that continues the same message.
        push_frame(1'b0, 4'h1, 1'b1, ENC_DIRECT, 64'd0, 0);
        push_frame(1'b1, 4'h9, 1'b1, ENC_DIRECT, 64'd2, 2);
        push_byte(8'h8F);
        push_close();

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        drain();
        while (bytes_queued < 420) begin
            push_random_unit();
        end
        drain();
        while (bytes_queued < 830) begin
            push_random_unit();
        end
        drain();
        repeat (5) @(posedge aclk);

        if (errors == 0 && deframed_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/wsdf_pkg.sv
rtl/wsdf_parser.sv
rtl/websocket_frame_deframer.sv
sim/tb_websocket_frame_deframer.sv
